[rtl/sirt_pkg.sv]
`default_nettype none

package sirt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   localparam int TIME_W   = 11;
   localparam int ROOM_W   = 8;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;
   localparam int COUNT_W  = 7;

   localparam logic [TIME_W-1:0] MINUTE_LIMIT = 11'd1439;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_FIND   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

   typedef struct packed {
      logic              action;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] stop_time;
      logic [ROOM_W-1:0] room_tag;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [TIME_W-1:0]   found_stop;
      logic [ROOM_W-1:0]   found_room;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   // one stored interval
   typedef struct packed {
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] stop_time;
      logic [ROOM_W-1:0] room_tag;
   } entry_type;

   // compare results of one cell against the pending request
   typedef struct packed {
      logic ahead;   // occupied and ends at or before the new start
      logic clash;   // occupied and overlaps the new interval
      logic match;   // occupied and start equals the key
   } cell_flags_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic      write_en;
      entry_type entry;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_COMMIT
   } state_type;

endpackage

`default_nettype wire

[rtl/sirt_cell.sv]
`default_nettype none

module sirt_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  wire logic                    clock,
   input  wire logic [CNT_W-1:0]        count,
   input  wire sirt_pkg::cell_ctl_type  ctl,
   input  wire sirt_pkg::entry_type     prev_entry,
   input  wire logic                    prev_ahead,
   output logic                         ahead,
   output sirt_pkg::entry_type          entry,
   output sirt_pkg::cell_flags_type     flags
);
   import sirt_pkg::*;

   entry_type      entry_ff, entry_in;
   cell_flags_type flags_ff, flags_in;
   logic           occupied;
   logic           after;

   assign occupied = CNT_W'(IDX) < count;
   assign after    = ctl.entry.stop_time <= entry_ff.start_time;

   always_comb begin
      flags_in.ahead = occupied && (entry_ff.stop_time <= ctl.entry.start_time);
      flags_in.clash = occupied && !flags_in.ahead && !after;
      flags_in.match = occupied && (entry_ff.start_time == ctl.entry.start_time);
   end

   // below the insert point: keep; at it: load new; above it: take neighbor
   always_comb begin
      entry_in = entry_ff;
      if (ctl.write_en && !flags_ff.ahead) begin
         if (prev_ahead) begin
            entry_in = ctl.entry;
         end else begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;
   assign ahead = flags_ff.ahead;

endmodule

`default_nettype wire

[rtl/sirt_reduce.sv]
`default_nettype none

module sirt_reduce #(
   parameter int TABLE_DEPTH = 64,
   parameter int IDX_W       = 6
) (
   input  wire sirt_pkg::cell_flags_type flags [TABLE_DEPTH],
   input  wire sirt_pkg::entry_type      entries [TABLE_DEPTH],
   output logic                          any_clash,
   output logic                          any_match,
   output logic [IDX_W-1:0]              match_idx,
   output sirt_pkg::entry_type           match_entry,
   output logic [IDX_W-1:0]              insert_idx
);
   import sirt_pkg::*;

   // starts are distinct, so at most one cell matches; ahead flags form a
   // thermometer, so at most one edge marks the insert point
   always_comb begin
      logic ins_hot;
      any_clash   = 1'b0;
      any_match   = 1'b0;
      match_idx   = '0;
      match_entry = '0;
      insert_idx  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         any_clash = any_clash | flags[i].clash;
         any_match = any_match | flags[i].match;
         if (flags[i].match) begin
            match_idx   = match_idx | IDX_W'(i);
            match_entry = match_entry | entries[i];
         end
         if (i == 0) begin
            ins_hot = !flags[i].ahead;
         end else begin
            ins_hot = !flags[i].ahead && flags[i-1].ahead;
         end
         if (ins_hot) begin
            insert_idx = insert_idx | IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/sorted_interval_reservation_table.sv]
// Sorted interval reservation table.
// Request channel (req_valid/req_ready/req_data): an insert of [start, stop)
// with a room tag, or a find by start time. Response channel
// (rsp_valid/rsp_ready/rsp_data): one response per request with status,
// slot, found stop/room and the entry count after the request.
// Entries live in a row of TABLE_DEPTH cells; each compares itself against
// the pending request and, on an insert, keeps, loads or takes its lower
// neighbor's entry, so the whole row shifts in parallel.
// Sequence: the request is registered on acceptance, the cells register
// their compares in the compare state, then the commit state loads the
// response register. A new request is taken only in the commit state (or
// in idle), so the block does not accept a request before the current one
// reaches its commit.
// If rsp_ready is low while a response waits, the commit of the next
// request holds and req_ready stays low until the output register frees.
// Reset empties the table (count to zero); entry storage is not cleared.
`default_nettype none

module sorted_interval_reservation_table #(
   parameter int TABLE_DEPTH = sirt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sirt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sirt_pkg::rsp_type      rsp_data
);
   import sirt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   cell_ctl_type     ctl;
   entry_type        cell_entry [TABLE_DEPTH];
   cell_flags_type   cell_flags [TABLE_DEPTH];
   logic             cell_ahead [TABLE_DEPTH];

   logic             any_clash, any_match;
   logic [IDX_W-1:0] match_idx, insert_idx;
   entry_type        match_entry;

   logic             out_free, commit, invalid, full, ins_ok;

   assign ctl.entry.start_time = req_ff.start_time;
   assign ctl.entry.stop_time  = req_ff.stop_time;
   assign ctl.entry.room_tag   = req_ff.room_tag;
   assign ctl.write_en         = ins_ok;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         sirt_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
            .clock      (clock),
            .count      (count_ff),
            .ctl        (ctl),
            .prev_entry (ctl.entry),
            .prev_ahead (1'b1),
            .ahead      (cell_ahead[i]),
            .entry      (cell_entry[i]),
            .flags      (cell_flags[i])
         );
      end else begin : g_body
         sirt_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
            .clock      (clock),
            .count      (count_ff),
            .ctl        (ctl),
            .prev_entry (cell_entry[i-1]),
            .prev_ahead (cell_ahead[i-1]),
            .ahead      (cell_ahead[i]),
            .entry      (cell_entry[i]),
            .flags      (cell_flags[i])
         );
      end
   end

   sirt_reduce #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_reduce (
      .flags       (cell_flags),
      .entries     (cell_entry),
      .any_clash   (any_clash),
      .any_match   (any_match),
      .match_idx   (match_idx),
      .match_entry (match_entry),
      .insert_idx  (insert_idx)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == ST_COMMIT) && out_free;
   assign invalid  = (req_ff.start_time >= req_ff.stop_time) ||
                     (req_ff.stop_time > MINUTE_LIMIT);
   assign full     = count_ff == CNT_W'(TABLE_DEPTH);
   assign ins_ok   = commit && (req_ff.action == ACT_INSERT) &&
                     !invalid && !any_clash && !full;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (ins_ok) begin
         count_in = count_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               req_ready    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.entry_count = COUNT_W'(count_in);
               if (req_ff.action == ACT_INSERT) begin
                  if (invalid) begin
                     rsp_in.status = ST_INVALID;
                  end else if (any_clash) begin
                     rsp_in.status = ST_OVERLAP;
                  end else if (full) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     rsp_in.status = ST_INSERTED;
                     rsp_in.slot   = SLOT_W'(insert_idx);
                  end
               end else if (any_match) begin
                  rsp_in.status     = ST_FOUND;
                  rsp_in.slot       = SLOT_W'(match_idx);
                  rsp_in.found_stop = match_entry.stop_time;
                  rsp_in.found_room = match_entry.room_tag;
               end else begin
                  rsp_in.status = ST_NOTFOUND;
               end
               state_in = req_valid ? ST_CMP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_in = req_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
